### hw/rtl/ihds_pkg.sv
`default_nettype none

package ihds_pkg;

  // Format codes held in the image_format register.
  localparam logic [1:0] FMT_JPEG = 2'd0;
  localparam logic [1:0] FMT_PNG  = 2'd1;
  localparam logic [1:0] FMT_BMP  = 2'd2;
  localparam logic [1:0] FMT_QOI  = 2'd3;

  // JPEG marker bytes.
  localparam logic [7:0] JPG_FILL    = 8'hFF;
  localparam logic [7:0] JPG_SOI     = 8'hD8;
  localparam logic [7:0] JPG_EOI     = 8'hD9;
  localparam logic [7:0] JPG_SOS     = 8'hDA;
  localparam logic [7:0] JPG_TEM     = 8'h01;
  localparam logic [7:0] JPG_RST_LO  = 8'hD0;
  localparam logic [7:0] JPG_SOF_LO  = 8'hC0;
  localparam logic [7:0] JPG_SOF_HI  = 8'hCF;
  localparam logic [7:0] JPG_DHT     = 8'hC4;
  localparam logic [7:0] JPG_JPG     = 8'hC8;
  localparam logic [7:0] JPG_DAC     = 8'hCC;

  // BMP signature bytes.
  localparam logic [7:0] BMP_SIG0 = 8'h42;
  localparam logic [7:0] BMP_SIG1 = 8'h4D;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_DONE   = 4'd1,
    PH_HDR    = 4'd2,
    PH_SOI    = 4'd3,
    PH_HUNT   = 4'd4,
    PH_MARK   = 4'd5,
    PH_LENHI  = 4'd6,
    PH_LENLO  = 4'd7,
    PH_FLENHI = 4'd8,
    PH_FLENLO = 4'd9,
    PH_SKIP   = 4'd10,
    PH_FRAME  = 4'd11
  } ihds_phase_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_of_file;
    logic       last_of_file;
  } ihds_in_t;

  typedef struct packed {
    logic        found;
    logic [30:0] pixel_width;
    logic [30:0] pixel_height;
  } ihds_out_t;

  function automatic logic [7:0] png_sig(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4E;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] qoi_sig(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0: v = 8'h71;
      2'd1: v = 8'h6F;
      2'd2: v = 8'h69;
      default: v = 8'h66;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ihds_in_reg.sv
`default_nettype none

module ihds_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ihds_pkg::ihds_in_t in_data,
  input  wire logic            take,
  output logic                 item_valid,
  output ihds_pkg::ihds_in_t   item
);
  import ihds_pkg::*;

  logic     valid_q;
  logic     valid_next;
  ihds_in_t data_q;
  logic     load;

  // The held request leaves when the parse stage takes it, freeing the slot.
  assign in_stall   = valid_q && !take;
  assign load       = in_valid && !in_stall;
  assign valid_next = load || (valid_q && !take);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= in_data;
    end
  end

  assign item_valid = valid_q;
  assign item       = data_q;

endmodule

`default_nettype wire

### hw/rtl/ihds_parser.sv
`default_nettype none

module ihds_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         image_format,
  input  wire logic               step_en,
  input  wire ihds_pkg::ihds_in_t item,
  output logic                    res_fire,
  output ihds_pkg::ihds_out_t     res_data
);
  import ihds_pkg::*;

  ihds_phase_t phase;
  logic [15:0] byte_count;
  logic [7:0]  len_high;
  logic [31:0] width_shift;
  logic [31:0] height_shift;
  logic        result_given;

  ihds_phase_t phase_next;
  logic [15:0] byte_count_next;
  logic [7:0]  len_high_next;
  logic [31:0] width_shift_next;
  logic [31:0] height_shift_next;
  logic        result_given_next;

  // State as seen after a first-of-file flag restarts the parse.
  ihds_phase_t ph0;
  logic [15:0] bc0;
  logic [7:0]  lh0;
  logic [31:0] ws0;
  logic [31:0] hs0;
  logic        rg0;

  logic [7:0]  b;
  logic        active;
  logic [31:0] ws_shl, hs_shl, ws_shr, hs_shr;
  logic [31:0] fr_ws, fr_hs;
  logic [15:0] seg_len;
  logic [15:0] skip_len;
  logic [15:0] bc_dec;
  logic        fire_parse;
  logic        fire_last;
  logic        dims_ok;
  logic [31:0] dim_w, dim_h;

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic dim_valid(input logic [31:0] v);
    return (v != 32'd0) && !v[31];
  endfunction

  assign b   = item.file_byte;
  assign ph0 = item.first_of_file ? ((image_format == FMT_JPEG) ? PH_SOI : PH_HDR) : phase;
  assign bc0 = item.first_of_file ? 16'd0 : byte_count;
  assign lh0 = item.first_of_file ? 8'd0 : len_high;
  assign ws0 = item.first_of_file ? 32'd0 : width_shift;
  assign hs0 = item.first_of_file ? 32'd0 : height_shift;
  assign rg0 = item.first_of_file ? 1'b0 : result_given;

  assign active   = (ph0 != PH_IDLE) && (ph0 != PH_DONE);
  assign ws_shl   = {ws0[23:0], b};
  assign hs_shl   = {hs0[23:0], b};
  assign ws_shr   = {b, ws0[31:8]};
  assign hs_shr   = {b, hs0[31:8]};
  assign fr_ws    = {16'd0, ws0[7:0], b};
  assign fr_hs    = {16'd0, hs0[7:0], b};
  assign seg_len  = {lh0, b};
  assign skip_len = seg_len - 16'd2;
  assign bc_dec   = bc0 - 16'd1;

  // Result decision: an early failure, finished dimensions, or a short file.
  always_comb begin
    fire_parse = 1'b0;
    dims_ok    = 1'b0;
    dim_w      = 32'd0;
    dim_h      = 32'd0;
    if (active) begin
      case (ph0)
        PH_HDR: begin
          case (image_format)
            FMT_PNG: begin
              if (bc0 < 16'd8) begin
                fire_parse = (b != png_sig(bc0[2:0]));
              end else if (bc0 == 16'd23) begin
                fire_parse = 1'b1;
                dim_w      = ws0;
                dim_h      = hs_shl;
                dims_ok    = 1'b1;
              end
            end
            FMT_BMP: begin
              if (bc0 == 16'd0) begin
                fire_parse = (b != BMP_SIG0);
              end else if (bc0 == 16'd1) begin
                fire_parse = (b != BMP_SIG1);
              end else if (bc0 == 16'd25) begin
                fire_parse = 1'b1;
                dim_w      = magnitude(ws0);
                dim_h      = magnitude(hs_shr);
                dims_ok    = 1'b1;
              end
            end
            FMT_QOI: begin
              if (bc0 < 16'd4) begin
                fire_parse = (b != qoi_sig(bc0[1:0]));
              end else if (bc0 == 16'd11) begin
                fire_parse = 1'b1;
                dim_w      = ws0;
                dim_h      = hs_shl;
                dims_ok    = 1'b1;
              end
            end
            default: begin
              // Register moved to JPEG in the middle of a fixed header.
              fire_parse = 1'b1;
            end
          endcase
        end
        PH_SOI: begin
          fire_parse = (bc0 == 16'd0) ? (b != JPG_FILL) : (b != JPG_SOI);
        end
        PH_MARK: begin
          fire_parse = (b == JPG_EOI) || (b == JPG_SOS);
        end
        PH_LENLO: begin
          fire_parse = (lh0 == 8'd0) && (b < 8'd2);
        end
        PH_FLENLO: begin
          fire_parse = (lh0 == 8'd0) && (b < 8'd7);
        end
        PH_FRAME: begin
          if (bc0 >= 16'd4) begin
            fire_parse = 1'b1;
            dim_w      = fr_ws;
            dim_h      = hs0;
            dims_ok    = 1'b1;
          end
        end
        default: begin
          fire_parse = 1'b0;
        end
      endcase
    end
    fire_last = item.last_of_file && !fire_parse && (ph0 != PH_IDLE) && !rg0;

    res_fire = fire_parse || fire_last;
    res_data = '0;
    if (fire_parse && dims_ok && dim_valid(dim_w) && dim_valid(dim_h)) begin
      res_data.found        = 1'b1;
      res_data.pixel_width  = dim_w[30:0];
      res_data.pixel_height = dim_h[30:0];
    end
  end

  // Next state of the parse.
  always_comb begin
    phase_next        = ph0;
    byte_count_next   = bc0;
    len_high_next     = lh0;
    width_shift_next  = ws0;
    height_shift_next = hs0;
    result_given_next = rg0;
    if (active) begin
      case (ph0)
        PH_HDR: begin
          byte_count_next = bc0 + 16'd1;
          case (image_format)
            FMT_PNG: begin
              if (bc0 >= 16'd16 && bc0 < 16'd20) begin
                width_shift_next = ws_shl;
              end else if (bc0 >= 16'd20 && bc0 < 16'd24) begin
                height_shift_next = hs_shl;
              end
            end
            FMT_BMP: begin
              if (bc0 >= 16'd18 && bc0 < 16'd22) begin
                width_shift_next = ws_shr;
              end else if (bc0 >= 16'd22 && bc0 < 16'd26) begin
                height_shift_next = hs_shr;
              end
            end
            FMT_QOI: begin
              if (bc0 >= 16'd4 && bc0 < 16'd8) begin
                width_shift_next = ws_shl;
              end else if (bc0 >= 16'd8 && bc0 < 16'd12) begin
                height_shift_next = hs_shl;
              end
            end
            default: begin
              byte_count_next = bc0 + 16'd1;
            end
          endcase
        end
        PH_SOI: begin
          if (bc0 == 16'd0) begin
            byte_count_next = 16'd1;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_HUNT: begin
          if (b == JPG_FILL) begin
            phase_next = PH_MARK;
          end
        end
        PH_MARK: begin
          if (b == JPG_FILL) begin
            phase_next = PH_MARK;
          end else if (b == JPG_TEM || (b >= JPG_RST_LO && b <= JPG_SOI)) begin
            phase_next = PH_HUNT;
          end else if (b >= JPG_SOF_LO && b <= JPG_SOF_HI && b != JPG_DHT &&
                       b != JPG_JPG && b != JPG_DAC) begin
            phase_next = PH_FLENHI;
          end else begin
            phase_next = PH_LENHI;
          end
        end
        PH_LENHI: begin
          len_high_next = b;
          phase_next    = PH_LENLO;
        end
        PH_FLENHI: begin
          len_high_next = b;
          phase_next    = PH_FLENLO;
        end
        PH_LENLO: begin
          byte_count_next = skip_len;
          phase_next      = (skip_len != 16'd0) ? PH_SKIP : PH_HUNT;
        end
        PH_FLENLO: begin
          byte_count_next   = 16'd0;
          width_shift_next  = 32'd0;
          height_shift_next = 32'd0;
          phase_next        = PH_FRAME;
        end
        PH_SKIP: begin
          byte_count_next = bc_dec;
          if (bc_dec == 16'd0) begin
            phase_next = PH_HUNT;
          end
        end
        PH_FRAME: begin
          if (bc0 == 16'd1 || bc0 == 16'd2) begin
            height_shift_next = fr_hs;
          end else if (bc0 >= 16'd3) begin
            width_shift_next = fr_ws;
          end
          byte_count_next = bc0 + 16'd1;
        end
        default: begin
          phase_next = ph0;
        end
      endcase
    end
    if (fire_parse) begin
      phase_next        = PH_DONE;
      result_given_next = 1'b1;
    end
    if (fire_last) begin
      result_given_next = 1'b1;
    end
    if (item.last_of_file) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_count   <= 16'd0;
      len_high     <= 8'd0;
      width_shift  <= 32'd0;
      height_shift <= 32'd0;
      result_given <= 1'b0;
    end else if (step_en) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      len_high     <= len_high_next;
      width_shift  <= width_shift_next;
      height_shift <= height_shift_next;
      result_given <= result_given_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ihds_out_reg.sv
`default_nettype none

module ihds_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire ihds_pkg::ihds_out_t load_data,
  output logic                     can_load,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ihds_pkg::ihds_out_t      out_data
);
  import ihds_pkg::*;

  logic      valid_q;
  logic      valid_next;
  ihds_out_t data_q;

  // The register is free when empty or when its request leaves this cycle.
  assign can_load   = !valid_q || !out_stall;
  assign valid_next = (load && can_load) || (valid_q && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data_q <= load_data;
    end
  end

  assign out_valid = valid_q;
  assign out_data  = data_q;

endmodule

`default_nettype wire

### hw/rtl/image_header_dimension_sniffer_core.sv
// Image header dimension sniffer.
// The input channel (in_valid, in_stall, in_data) carries one byte of an image
// file per request, with first-of-file and last-of-file flags. For each file
// the block sends exactly one request on the output channel (out_valid,
// out_stall, out_data): found with the pixel width and height, or a failure
// with zero dimensions. Bytes after that result are dropped until the next
// first-of-file byte. The format (JPEG, PNG, BMP, QOI) is set through
// cfg_wr_en and cfg_wr_data; the user must write it only while no file is
// in flight, which the block does not enforce. A byte accepted into the
// input register is parsed when it leaves it, and any result it causes is
// loaded into the result register as it leaves. The block takes one byte
// per cycle while no result is stalled, parsing it combinationally between
// the two registers. Reset clears the input and result registers, the parse
// state and the format register (JPEG). When the receiver stalls, the result
// is held; one more byte waits in the input register, after which in_stall
// is raised until the result is taken.
`default_nettype none

module image_header_dimension_sniffer_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ihds_pkg::ihds_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ihds_pkg::ihds_out_t      out_data
);
  import ihds_pkg::*;

  logic [1:0] image_format;
  logic       item_valid;
  ihds_in_t   item;
  logic       can_load;
  logic       advance;
  logic       res_fire;
  ihds_out_t  res_data;

  // Format register; software must write it only between files (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      image_format <= FMT_JPEG;
    end else if (cfg_wr_en) begin
      image_format <= cfg_wr_data;
    end
  end

  // A byte is parsed when it is held and the result register can take
  // whatever it produces.
  assign advance = item_valid && can_load;

  ihds_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ihds_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .image_format (image_format),
    .step_en      (advance),
    .item         (item),
    .res_fire     (res_fire),
    .res_data     (res_data)
  );

  ihds_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_fire),
    .load_data (res_data),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/ihds_checker.sv
`default_nettype none

module ihds_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ihds_pkg::ihds_out_t out_data
);
  import ihds_pkg::*;

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A failure carries zero dimensions.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |->
      (out_data.pixel_width == 31'd0) && (out_data.pixel_height == 31'd0))
    else $error("failure result with nonzero size");

  // A success carries positive dimensions.
  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |->
      (out_data.pixel_width != 31'd0) && (out_data.pixel_height != 31'd0))
    else $error("found result with zero size");

  // The input side only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A fresh result comes from a byte held in the input register and then parsed.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching byte");

endmodule

bind image_header_dimension_sniffer_core ihds_checker u_ihds_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
